// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cdsd_pkg.sv =====
`default_nettype none
package cdsd_pkg;

  // fixed field widths
  localparam int CNT_W  = 6;
  localparam int RAND_W = 32;
  localparam int RANK_W = 4;
  localparam int SUIT_W = 2;
  localparam int OPC_W  = 2;

  // modulo unit: remainder bits resolved per cycle
  localparam int MOD_DIGIT = 4;
  localparam int MOD_STEPS = RAND_W / MOD_DIGIT;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // opcode encodings on the input port
  localparam logic [OPC_W-1:0] OPC_RESET = 2'd0;
  localparam logic [OPC_W-1:0] OPC_BEGIN = 2'd1;
  localparam logic [OPC_W-1:0] OPC_STEP  = 2'd2;
  localparam logic [OPC_W-1:0] OPC_DEAL  = 2'd3;

  typedef enum logic [1:0] {
    OP_RESET,
    OP_BEGIN,
    OP_STEP,
    OP_DEAL
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [RAND_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [SUIT_W-1:0] suit;
    logic              card_valid;
    logic              refilled;
    logic              shuffle_done;
    logic [CNT_W-1:0]  cards_left;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SREAD,
    ST_SWAP1,
    ST_SWAP2,
    ST_DREAD,
    ST_DDATA,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/cdsd_ram.sv =====
`default_nettype none
module cdsd_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 52,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== rtl/core/cdsd_mod.sv =====
`default_nettype none
module cdsd_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cdsd_pkg::RAND_W-1:0] dividend,
  input  logic [cdsd_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [cdsd_pkg::CNT_W-1:0]  rem
);
  import cdsd_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] step_cnt;
  logic [RAND_W-1:0] shreg;
  logic [CNT_W:0]    part;
  logic [CNT_W:0]    part_next;
  logic [CNT_W-1:0]  dvs;

  // restoring remainder, several dividend bits per cycle
  always_comb begin
    part_next = part;
    for (int i = 0; i < MOD_DIGIT; i++) begin
      part_next = {part_next[CNT_W-1:0], shreg[RAND_W-1-i]};
      if (part_next >= {1'b0, dvs}) begin
        part_next = part_next - {1'b0, dvs};
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step_cnt <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == STEP_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      part  <= '0;
      dvs   <= divisor;
    end else if (busy) begin
      shreg <= shreg << MOD_DIGIT;
      part  <= part_next;
    end
  end

  assign rem = part[CNT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/cdsd_front.sv =====
`default_nettype none
module cdsd_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cdsd_pkg::OPC_W-1:0]  opcode,
  input  logic [cdsd_pkg::RAND_W-1:0] rand_word,
  output logic                        q_valid,
  input  logic                        q_ready,
  output cdsd_pkg::cmd_t              q_cmd
);
  import cdsd_pkg::*;

  cmd_t               slot [QUEUE_DEPTH];
  cmd_t               new_cmd;
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               push;
  logic               pop;

  // classify the incoming transaction
  always_comb begin
    unique case (opcode)
      OPC_RESET: new_cmd.op = OP_RESET;
      OPC_BEGIN: new_cmd.op = OP_BEGIN;
      OPC_STEP:  new_cmd.op = OP_STEP;
      OPC_DEAL:  new_cmd.op = OP_DEAL;
      default:   new_cmd.op = OP_DEAL;
    endcase
    new_cmd.word = (new_cmd.op == OP_STEP) ? rand_word : '0;
  end

  assign in_ready = (fill != QFILL_W'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_cmd    = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cdsd_back.sv =====
`default_nettype none
module cdsd_back #(
  parameter int NUM_SUITS = 4,
  parameter int NUM_RANKS = 13
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  cdsd_pkg::cmd_t q_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output cdsd_pkg::res_t out_res
);
  import cdsd_pkg::*;

  localparam int DECK_SIZE = NUM_SUITS * NUM_RANKS;
  localparam int IDX_W     = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
  localparam int CARD_W    = SUIT_W + RANK_W;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   cursor;
  logic [DECK_SIZE-1:0] vbits;
  logic [IDX_W-1:0]   addr_a;
  logic [IDX_W-1:0]   addr_b;
  logic [CARD_W-1:0]  tmp_a;
  res_t               res;
  res_t               idle_res;

  logic               mod_start;
  logic               mod_done;
  logic [CNT_W-1:0]   mod_rem;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [CARD_W-1:0]  ram_wdata;
  logic [CARD_W-1:0]  rd_a;
  logic [CARD_W-1:0]  rd_b;
  logic [CARD_W-1:0]  eff_a;
  logic [CARD_W-1:0]  eff_b;
  logic               out_load;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cur_clamp;

  // card at a given place of the ordered deck
  function automatic logic [CARD_W-1:0] ordered_card(input logic [IDX_W-1:0] idx);
    logic [CNT_W:0]    pos;
    logic [CNT_W:0]    rank_full;
    logic [SUIT_W-1:0] s_sel;
    pos       = (CNT_W + 1)'(idx);
    rank_full = pos + 1'b1;
    s_sel     = '0;
    for (int s = 1; s < NUM_SUITS; s++) begin
      if (pos >= (CNT_W + 1)'(s * NUM_RANKS)) begin
        s_sel     = SUIT_W'(s);
        rank_full = pos - (CNT_W + 1)'(s * NUM_RANKS) + 1'b1;
      end
    end
    return {s_sel, rank_full[RANK_W-1:0]};
  endfunction

  cdsd_ram #(
    .WIDTH(CARD_W),
    .DEPTH(DECK_SIZE)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(addr_a),
    .raddr_b(addr_b),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  cdsd_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .dividend(q_cmd.word),
    .divisor (cursor + 1'b1),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // entries never written since the last reload read as the ordered deck
  assign eff_a = vbits[addr_a] ? rd_a : ordered_card(addr_a);
  assign eff_b = vbits[addr_b] ? rd_b : ordered_card(addr_b);

  // deal bookkeeping: new count and cursor clamped to the new top
  assign cnt_m1 = count - 1'b1;
  always_comb begin
    if (cnt_m1 == '0) begin
      cur_clamp = '0;
    end else if (cursor >= cnt_m1) begin
      cur_clamp = cnt_m1 - 1'b1;
    end else begin
      cur_clamp = cursor;
    end
  end

  // result of the commands that finish without the deck memory
  always_comb begin
    idle_res = '0;
    case (q_cmd.op)
      OP_RESET: begin
        idle_res.shuffle_done = 1'b1;
        idle_res.cards_left   = CNT_W'(DECK_SIZE);
      end
      OP_BEGIN: begin
        idle_res.shuffle_done = (count == '0) || (cnt_m1 == '0);
        idle_res.cards_left   = count;
      end
      OP_STEP: begin
        idle_res.shuffle_done = 1'b1;
        idle_res.cards_left   = count;
      end
      default: begin
        idle_res.refilled     = 1'b1;
        idle_res.shuffle_done = 1'b1;
        idle_res.cards_left   = CNT_W'(DECK_SIZE);
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_STEP:  state_next = (cursor != '0) ? ST_MOD : ST_DONE;
            OP_DEAL:  state_next = (count != '0) ? ST_DREAD : ST_DONE;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_MOD:   state_next = mod_done ? ST_SREAD : ST_MOD;
      ST_SREAD: state_next = ST_SWAP1;
      ST_SWAP1: state_next = ST_SWAP2;
      ST_SWAP2: state_next = ST_DONE;
      ST_DREAD: state_next = ST_DDATA;
      ST_DDATA: state_next = ST_DONE;
      ST_DONE:  state_next = (!out_valid || out_ready) ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_ready   = 1'b0;
    mod_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = addr_a;
    ram_wdata = eff_b;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready   = 1'b1;
        mod_start = q_valid && (q_cmd.op == OP_STEP) && (cursor != '0);
      end
      ST_SWAP1: begin
        ram_we = 1'b1;
      end
      ST_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b;
        ram_wdata = tmp_a;
      end
      ST_DONE: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  // state and deck bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= CNT_W'(DECK_SIZE);
      cursor <= '0;
      vbits  <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_cmd.op)
              OP_RESET: begin
                count  <= CNT_W'(DECK_SIZE);
                cursor <= '0;
                vbits  <= '0;
              end
              OP_BEGIN: begin
                cursor <= (count != '0) ? cnt_m1 : '0;
              end
              OP_DEAL: begin
                if (count == '0) begin
                  count  <= CNT_W'(DECK_SIZE);
                  cursor <= '0;
                  vbits  <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SWAP1: vbits[addr_a] <= 1'b1;
        ST_SWAP2: begin
          vbits[addr_b] <= 1'b1;
          cursor        <= cursor - 1'b1;
        end
        ST_DDATA: begin
          count  <= cnt_m1;
          cursor <= cur_clamp;
        end
        default: begin
        end
      endcase
    end
  end

  // addresses, swap holding register and result assembly
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        addr_a <= cnt_m1[IDX_W-1:0];
        res    <= idle_res;
      end
      ST_MOD: begin
        addr_a <= cursor[IDX_W-1:0];
        addr_b <= mod_rem[IDX_W-1:0];
      end
      ST_SWAP1: tmp_a <= eff_a;
      ST_SWAP2: begin
        res.rank         <= '0;
        res.suit         <= '0;
        res.card_valid   <= 1'b0;
        res.refilled     <= 1'b0;
        res.shuffle_done <= (cursor == CNT_W'(1));
        res.cards_left   <= count;
      end
      ST_DDATA: begin
        res.rank         <= eff_a[RANK_W-1:0];
        res.suit         <= eff_a[CARD_W-1:RANK_W];
        res.card_valid   <= 1'b1;
        res.refilled     <= 1'b0;
        res.shuffle_done <= (cur_clamp == '0);
        res.cards_left   <= cnt_m1;
      end
      default: begin
      end
    endcase
  end

  // result register toward the output port
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/card_deck_shuffle_deal_unit.sv =====
// channel | signals                            | direction | handshake
// input   | opcode, rand_word                  | in        | in_valid / in_ready
// result  | card_rank, card_suit, card_valid,  | out       | out_valid / out_ready
//         | refilled, shuffle_done, cards_left |           |
//
// every transaction gives one result; a two-entry command queue takes input while the
// executor works, and the executor holds its last state until the result register frees.
// reset deck, shuffle begin, empty deal: from the idle state straight to the done state.
// deal: through the read and data states, for the registered read of the deck memory.
// shuffle step: 4-bit-per-cycle remainder unit, a read and 2 writes; at cursor 0 none.
// synchronous reset; the deck reads as ordered at once through per-entry valid bits.
`default_nettype none
module card_deck_shuffle_deal_unit #(
  parameter int NUM_SUITS = 4,
  parameter int NUM_RANKS = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cdsd_pkg::OPC_W-1:0]  opcode,
  input  logic [cdsd_pkg::RAND_W-1:0] rand_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cdsd_pkg::RANK_W-1:0] card_rank,
  output logic [cdsd_pkg::SUIT_W-1:0] card_suit,
  output logic                        card_valid,
  output logic                        refilled,
  output logic                        shuffle_done,
  output logic [cdsd_pkg::CNT_W-1:0]  cards_left
);
  import cdsd_pkg::*;

  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;
  res_t out_res;

  // front: accept and classify
  cdsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .rand_word(rand_word),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  // back: deck state, shuffle and deal
  cdsd_back #(
    .NUM_SUITS(NUM_SUITS),
    .NUM_RANKS(NUM_RANKS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign card_rank    = out_res.rank;
  assign card_suit    = out_res.suit;
  assign card_valid   = out_res.card_valid;
  assign refilled     = out_res.refilled;
  assign shuffle_done = out_res.shuffle_done;
  assign cards_left   = out_res.cards_left;

endmodule
`default_nettype wire

// ===== rtl/core/cdsd_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module cdsd_checker #(
  parameter int NUM_SUITS = 4,
  parameter int NUM_RANKS = 13
) (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] card_rank,
  input logic [1:0] card_suit,
  input logic       card_valid,
  input logic       refilled,
  input logic       shuffle_done,
  input logic [5:0] cards_left
);

  localparam int DECK_SIZE = NUM_SUITS * NUM_RANKS;

  // a stalled result stays valid and keeps its card and card count
  `CHK_ASSERT(a_out_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(card_rank) && $stable(card_suit)
      && $stable(cards_left),
    "result changed while stalled")

  // count never exceeds a full deck
  `CHK_ASSERT(a_count_range, clk, rst, out_valid |-> cards_left <= DECK_SIZE,
    "cards_left above deck size")

  // a dealt card is a real card, otherwise rank and suit are zero
  `CHK_ASSERT(a_card_legal, clk, rst,
    out_valid |-> (card_valid
      ? (card_rank != 4'd0 && card_rank <= NUM_RANKS && card_suit < NUM_SUITS)
      : (card_rank == 4'd0 && card_suit == 2'd0)),
    "illegal card on result")

  // a refill deals nothing, leaves a full deck and no shuffle in progress
  `CHK_ASSERT(a_refill, clk, rst,
    out_valid && refilled |-> !card_valid && shuffle_done && cards_left == DECK_SIZE,
    "inconsistent refill result")

  // no result is shown in the cycle after a reset cycle
  `CHK_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid, "result valid right after reset")

endmodule

bind card_deck_shuffle_deal_unit cdsd_checker #(
  .NUM_SUITS(NUM_SUITS),
  .NUM_RANKS(NUM_RANKS)
) u_checker (.*);
`default_nettype wire
